[rtl/core/fnas_pkg.sv]
// Package holding the shared types, codes and constants of the FIFO node allocation scheduler.
package fnas_pkg;

	localparam int CNT_W             = 7;
	localparam int DUR_W             = 16;
	localparam int NODE_W            = 7;
	localparam int POOL_MIN          = 16;
	localparam int DEF_WAIT_DEPTH    = 64;
	localparam int DEF_MAX_NODES     = 64;
	localparam int DEF_DURATION_BITS = 16;

	localparam logic CMD_SUBMIT = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic              command;
		logic [DUR_W-1:0]  job_duration;
		logic [NODE_W-1:0] job_nodes;
	} item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [NODE_W-1:0] free_nodes;
		logic [CNT_W-1:0]  admitted_count;
		logic [CNT_W-1:0]  finished_count;
		logic [CNT_W-1:0]  waiting_count;
		logic [CNT_W-1:0]  running_count;
		logic [31:0]       submitted_total;
		logic [31:0]       completed_total;
		logic [47:0]       busy_node_sum;
		logic [31:0]       tick_total;
	} result_t;

	// One stored job: remaining duration and node count.
	typedef struct packed {
		logic [DUR_W-1:0]  dur;
		logic [NODE_W-1:0] nod;
	} job_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_ADM_RD,
		S_ADM_CHK,
		S_CNT_RD,
		S_CNT_WR,
		S_FINISH,
		S_RESP
	} state_t;

	typedef struct packed {
		logic ld_item;
		logic do_submit;
		logic admit;
		logic cnt_step;
		logic finish;
		logic cfg_wr;
	} ctrl_t;

	typedef struct packed {
		logic is_tick;
		logic can_admit;
		logic more_run;
	} stat_t;

endpackage

[rtl/core/fnas_ctrl.sv]
// Controller state machine that sequences submits, admission and the countdown pass.
module fnas_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  fnas_pkg::stat_t stat,
	output fnas_pkg::ctrl_t ctrl
);

	fnas_pkg::state_t state_q;
	fnas_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fnas_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx  = state_q;
		ctrl      = '0;
		busy      = 1'b1;
		done      = 1'b0;
		cfg_ready = 1'b0;
		unique case (state_q)
			fnas_pkg::S_IDLE: begin
				busy        = 1'b0;
				cfg_ready   = 1'b1;
				ctrl.cfg_wr = cfg_valid;
				if (start) begin
					ctrl.ld_item = 1'b1;
					state_nx     = fnas_pkg::S_DECODE;
				end
			end
			fnas_pkg::S_DECODE: begin
				if (stat.is_tick) begin
					state_nx = fnas_pkg::S_ADM_RD;
				end else begin
					ctrl.do_submit = 1'b1;
					state_nx       = fnas_pkg::S_RESP;
				end
			end
			fnas_pkg::S_ADM_RD: begin
				state_nx = fnas_pkg::S_ADM_CHK;
			end
			fnas_pkg::S_ADM_CHK: begin
				if (stat.can_admit) begin
					ctrl.admit = 1'b1;
					state_nx   = fnas_pkg::S_ADM_RD;
				end else begin
					state_nx = fnas_pkg::S_CNT_RD;
				end
			end
			fnas_pkg::S_CNT_RD: begin
				state_nx = stat.more_run ? fnas_pkg::S_CNT_WR : fnas_pkg::S_FINISH;
			end
			fnas_pkg::S_CNT_WR: begin
				ctrl.cnt_step = 1'b1;
				state_nx      = fnas_pkg::S_CNT_RD;
			end
			fnas_pkg::S_FINISH: begin
				ctrl.finish = 1'b1;
				state_nx    = fnas_pkg::S_RESP;
			end
			fnas_pkg::S_RESP: begin
				done     = 1'b1;
				state_nx = fnas_pkg::S_IDLE;
			end
			default: begin
				state_nx = fnas_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/fnas_dpath.sv]
// Datapath with the waiting queue, the running slots, the node pool and the statistics.
module fnas_dpath #(
	parameter int WAIT_DEPTH    = fnas_pkg::DEF_WAIT_DEPTH,
	parameter int MAX_NODES     = fnas_pkg::DEF_MAX_NODES,
	parameter int DURATION_BITS = fnas_pkg::DEF_DURATION_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fnas_pkg::item_t                     item,
	input  logic [fnas_pkg::NODE_W-1:0]         cfg_data,
	input  fnas_pkg::ctrl_t                     ctrl,
	output fnas_pkg::stat_t                     stat,
	output fnas_pkg::result_t                   result
);

	localparam int WAW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int WFW = $clog2(WAIT_DEPTH + 1);
	localparam int RAW = $clog2(MAX_NODES);
	localparam int NW  = fnas_pkg::NODE_W;
	localparam int CW  = fnas_pkg::CNT_W;
	localparam int DUR_W_L = fnas_pkg::DUR_W;
	localparam logic [32:0] DUR_LIMIT = (33'd1 << DURATION_BITS) - 33'd1;
	localparam logic [NW-1:0] NODE_MAX = NW'(MAX_NODES);
	localparam logic [NW-1:0] NODE_MIN = NW'(fnas_pkg::POOL_MIN);

	fnas_pkg::job_t wait_mem [WAIT_DEPTH];
	fnas_pkg::job_t run_mem  [MAX_NODES];

	fnas_pkg::item_t  item_q;
	fnas_pkg::job_t   wait_rd_q;
	fnas_pkg::job_t   run_rd_q;
	logic [NW-1:0]    node_count_q;
	logic [NW-1:0]    free_q;
	logic [WAW-1:0]   head_q;
	logic [WFW-1:0]   fill_q;
	logic [CW-1:0]    run_fill_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    keep_q;
	logic [1:0]       status_q;
	logic [CW-1:0]    admitted_q;
	logic [CW-1:0]    finished_q;
	logic [31:0]      submitted_q;
	logic [31:0]      completed_q;
	logic [47:0]      busy_sum_q;
	logic [31:0]      tick_q;

	logic             bad_job;
	logic [WFW:0]     tail_sum;
	logic [WAW-1:0]   tail;
	logic [WAW-1:0]   head_inc;
	logic [DUR_W_L-1:0] dec_dur;
	logic             job_done;
	logic [NW:0]      free_add;
	logic [NW-1:0]    free_ret;
	logic [NW-1:0]    nc_clamp;
	logic [NW-1:0]    busy_now;
	logic [NW-1:0]    busy_end;
	logic [48:0]      busy_add;

	always_comb begin
		bad_job = (item_q.job_duration == '0) ||
			({17'd0, item_q.job_duration} > DUR_LIMIT) ||
			(item_q.job_nodes == '0) || (item_q.job_nodes > node_count_q);
		tail_sum = (WFW+1)'(head_q) + (WFW+1)'(fill_q);
		if (tail_sum >= (WFW+1)'(WAIT_DEPTH)) begin
			tail = WAW'(tail_sum - (WFW+1)'(WAIT_DEPTH));
		end else begin
			tail = WAW'(tail_sum);
		end
		if (32'(head_q) == 32'(WAIT_DEPTH - 1)) begin
			head_inc = '0;
		end else begin
			head_inc = head_q + WAW'(1);
		end
		dec_dur  = run_rd_q.dur - DUR_W_L'(1);
		job_done = (dec_dur == '0);
		free_add = {1'b0, free_q} + {1'b0, run_rd_q.nod};
		free_ret = (free_add > {1'b0, node_count_q}) ? node_count_q : free_add[NW-1:0];
		if (cfg_data < NODE_MIN) begin
			nc_clamp = NODE_MIN;
		end else if (cfg_data > NODE_MAX) begin
			nc_clamp = NODE_MAX;
		end else begin
			nc_clamp = cfg_data;
		end
		busy_now = node_count_q - free_q;
		busy_end = node_count_q - free_q;
		busy_add = {1'b0, busy_sum_q} + 49'(busy_end);
	end

	assign stat.is_tick   = (item_q.command == fnas_pkg::CMD_TICK);
	assign stat.can_admit = (fill_q != '0) && (run_fill_q < CW'(MAX_NODES)) &&
		(wait_rd_q.nod <= free_q);
	assign stat.more_run  = (idx_q < run_fill_q);

	// Memory ports: registered reads every cycle, one write port each.
	always_ff @(posedge clk) begin
		wait_rd_q <= wait_mem[head_q];
		run_rd_q  <= run_mem[idx_q[RAW-1:0]];
		if (ctrl.do_submit && !bad_job && (32'(fill_q) < 32'(WAIT_DEPTH))) begin
			wait_mem[tail] <= '{dur: item_q.job_duration, nod: item_q.job_nodes};
		end
		if (ctrl.admit) begin
			run_mem[run_fill_q[RAW-1:0]] <= wait_rd_q;
		end else if (ctrl.cnt_step && !job_done) begin
			run_mem[keep_q[RAW-1:0]] <= '{dur: dec_dur, nod: run_rd_q.nod};
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_item) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_MAX;
			free_q       <= NODE_MAX;
			head_q       <= '0;
			fill_q       <= '0;
			run_fill_q   <= '0;
			idx_q        <= '0;
			keep_q       <= '0;
			status_q     <= fnas_pkg::ST_OK;
			admitted_q   <= '0;
			finished_q   <= '0;
			submitted_q  <= '0;
			completed_q  <= '0;
			busy_sum_q   <= '0;
			tick_q       <= '0;
		end else begin
			if (ctrl.cfg_wr) begin
				node_count_q <= nc_clamp;
				free_q       <= (nc_clamp >= busy_now) ? nc_clamp - busy_now : '0;
			end
			if (ctrl.ld_item) begin
				status_q   <= fnas_pkg::ST_OK;
				admitted_q <= '0;
				finished_q <= '0;
				idx_q      <= '0;
				keep_q     <= '0;
			end
			if (ctrl.do_submit) begin
				if (bad_job) begin
					status_q <= fnas_pkg::ST_INVALID;
				end else if (32'(fill_q) >= 32'(WAIT_DEPTH)) begin
					status_q <= fnas_pkg::ST_FULL;
				end else begin
					fill_q <= fill_q + WFW'(1);
					if (submitted_q != '1) begin
						submitted_q <= submitted_q + 32'd1;
					end
				end
			end
			if (ctrl.admit) begin
				free_q     <= free_q - wait_rd_q.nod;
				run_fill_q <= run_fill_q + CW'(1);
				head_q     <= head_inc;
				fill_q     <= fill_q - WFW'(1);
				admitted_q <= admitted_q + CW'(1);
			end
			if (ctrl.cnt_step) begin
				idx_q <= idx_q + CW'(1);
				if (job_done) begin
					free_q     <= free_ret;
					finished_q <= finished_q + CW'(1);
					if (completed_q != '1) begin
						completed_q <= completed_q + 32'd1;
					end
				end else begin
					keep_q <= keep_q + CW'(1);
				end
			end
			if (ctrl.finish) begin
				run_fill_q <= keep_q;
				busy_sum_q <= busy_add[48] ? '1 : busy_add[47:0];
				if (tick_q != '1) begin
					tick_q <= tick_q + 32'd1;
				end
			end
		end
	end

	always_comb begin
		result.status          = status_q;
		result.free_nodes      = free_q;
		result.admitted_count  = admitted_q;
		result.finished_count  = finished_q;
		result.waiting_count   = CW'(fill_q);
		result.running_count   = run_fill_q;
		result.submitted_total = submitted_q;
		result.completed_total = completed_q;
		result.busy_node_sum   = busy_sum_q;
		result.tick_total      = tick_q;
	end

endmodule

[rtl/core/fifo_node_allocation_scheduler.sv]
// Top level of the FIFO node allocation scheduler: controller plus datapath.
//
// Usage. An item is a command: submit a job (duration and node count) into the
// waiting queue, or advance time by one tick. An item transfer happens at a
// rising edge with start high and busy low; item carries the fields.
// Each item produces exactly one result, shown on result for a single cycle
// while done is high. The receiver cannot hold a result off, so none is ever
// stalled; the block simply drops busy again in the cycle after done.
// A submit passes from transfer through decode to done. A tick runs
// the admission walk over the waiting queue and then the countdown pass over
// the running jobs; each reads one memory entry at a time through a registered
// read port, a read state followed by a check or write state per entry.
// Throughput is one item at a time, so the next item follows after done.
// The node pool size register is written over the cfg channel (cfg_valid,
// cfg_ready, cfg_data); cfg_ready is high only while the block is idle.
// Reset: the pool holds MAX_NODES nodes, all free, both queues empty and all
// statistics zero. The queue memories are not cleared; no entry is read before
// it is written, so no clearing pass is needed.
module fifo_node_allocation_scheduler #(
	parameter int WAIT_DEPTH    = fnas_pkg::DEF_WAIT_DEPTH,
	parameter int MAX_NODES     = fnas_pkg::DEF_MAX_NODES,
	parameter int DURATION_BITS = fnas_pkg::DEF_DURATION_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  fnas_pkg::item_t             item,
	output logic                        done,
	output fnas_pkg::result_t           result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fnas_pkg::NODE_W-1:0] cfg_data
);

	fnas_pkg::ctrl_t ctrl;
	fnas_pkg::stat_t stat;

	// The controller owns the handshakes and sequences the datapath.
	fnas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.done      (done),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// The datapath holds both job stores, the pool and the counters.
	fnas_dpath #(
		.WAIT_DEPTH    (WAIT_DEPTH),
		.MAX_NODES     (MAX_NODES),
		.DURATION_BITS (DURATION_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_data (cfg_data),
		.ctrl     (ctrl),
		.stat     (stat),
		.result   (result)
	);

endmodule

[rtl/core/fnas_checker.sv]
// Port-level checker for the FIFO node allocation scheduler and its bind.
module fnas_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic              cfg_ready,
	input fnas_pkg::result_t result
);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after an item transfer");

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (busy && !cfg_ready))
		else $error("result shown while idle");

	a_reject_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != fnas_pkg::ST_OK) |->
		(result.admitted_count == '0 && result.finished_count == '0))
		else $error("rejected submit reports tick activity");

endmodule

bind fifo_node_allocation_scheduler fnas_checker u_fnas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_ready (cfg_ready),
	.result    (result)
);
